[rtl/dqr_pkg.sv]
// Shared types and constants for the DNS query/reply byte stream unit.
// Used by every module under rtl; depends on nothing else.
package dqr_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned RCODE_W     = 4;
    localparam int unsigned QTYPE_W     = 16;
    localparam int unsigned REPLY_LEN_W = 10;
    localparam int unsigned CNT_AFTER_W = 3;

    // Header layout
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned IDX_FLAGS_HI = 2;
    localparam int unsigned IDX_FLAGS_LO = 3;
    localparam int unsigned IDX_COUNTS   = 6;

    // Flag masks and characters
    localparam logic [BYTE_W-1:0] QR_MASK    = 8'h80;
    localparam logic [BYTE_W-1:0] RD_MASK    = 8'h01;
    localparam logic [BYTE_W-1:0] OPHI_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;

    // Question tail: QTYPE plus QCLASS
    localparam logic [CNT_AFTER_W-1:0] TAIL_BYTES  = 3'd4;
    localparam logic [CNT_AFTER_W-1:0] QTYPE_BYTES = 3'd2;

    // Output word packing
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_AFTER
    } parse_phase_t;

    // One request byte as held by the input register
    typedef struct packed {
        logic [BYTE_W-1:0] request_byte;
        logic              last_byte;
    } in_word_t;

    // One result word handed from the parser to the output register
    typedef struct packed {
        logic [BYTE_W-1:0]      reply_byte;
        logic                   in_reply;
        logic [BYTE_W-1:0]      name_char;
        logic                   name_char_valid;
        logic [QTYPE_W-1:0]     query_type;
        logic [REPLY_LEN_W-1:0] reply_length;
        logic                   end_of_message;
    } result_t;

endpackage

[rtl/dqr_in_stage.sv]
// Input register for request bytes.
// Depends on dqr_pkg for the in_word_t type.
module dqr_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,      // [7:0] request_byte
    input  logic             s_tlast,      // last_byte
    input  logic             take,
    output logic             word_valid,
    output dqr_pkg::in_word_t word
);

    logic              valid_reg;
    dqr_pkg::in_word_t word_reg;

    // Register is free when empty or being drained this cycle
    assign s_tready   = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg.request_byte <= s_tdata;
            word_reg.last_byte    <= s_tlast;
        end
    end

endmodule

[rtl/dqr_parse.sv]
// Per-byte parse step: header rewrite, QNAME walk, QTYPE capture, reply length.
// Holds the parse state and the rcode register; depends on dqr_pkg.
module dqr_parse
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rcode_wr_en,
    input  logic [3:0]        rcode_wr_data,
    input  logic              word_valid,
    input  dqr_pkg::in_word_t word,
    input  logic              res_ready,
    output logic              take,
    output dqr_pkg::result_t  res
);

    localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int unsigned SUM_W = (POS_W + 1 > dqr_pkg::REPLY_LEN_W) ?
                                    POS_W + 1 : dqr_pkg::REPLY_LEN_W;

    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_HDR  = POS_W'(dqr_pkg::HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_HDRL = POS_W'(dqr_pkg::HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_FHI  = POS_W'(dqr_pkg::IDX_FLAGS_HI);
    localparam logic [POS_W-1:0] POS_FLO  = POS_W'(dqr_pkg::IDX_FLAGS_LO);
    localparam logic [POS_W-1:0] POS_CNT  = POS_W'(dqr_pkg::IDX_COUNTS);

    logic [3:0]              rcode_reg;
    logic [POS_W-1:0]        pos_reg,        pos_next;
    dqr_pkg::parse_phase_t   phase_reg,      phase_next;
    logic [7:0]              label_left_reg, label_left_next;
    logic                    first_reg,      first_next;
    logic [2:0]              after_reg,      after_next;
    logic [7:0]              type_hi_reg,    type_hi_next;
    logic [15:0]             type_reg,       type_next;
    logic [POS_W-1:0]        name_end_reg,   name_end_next;

    logic [7:0]              b;
    logic [7:0]              label_dec;
    logic [SUM_W-1:0]        sum_len;

    assign take = word_valid && res_ready;
    assign b    = word.request_byte;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcode_reg <= '0;
        end
        else if (rcode_wr_en)
        begin
            rcode_reg <= rcode_wr_data;
        end
    end

    // Parse step for the byte in the input register
    always_comb
    begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        label_left_next = label_left_reg;
        first_next      = first_reg;
        after_next      = after_reg;
        type_hi_next    = type_hi_reg;
        type_next       = type_reg;
        name_end_next   = name_end_reg;
        label_dec       = (label_left_reg != 8'd0) ? label_left_reg - 8'd1 : 8'd0;
        sum_len         = '0;

        res                 = '0;
        res.end_of_message  = word.last_byte;

        if (pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                dqr_pkg::PH_HEADER:
                begin
                    res.in_reply = 1'b1;
                    if (pos_reg == POS_FHI)
                    begin
                        res.reply_byte = (b | dqr_pkg::QR_MASK) & ~dqr_pkg::RD_MASK;
                    end
                    else if (pos_reg == POS_FLO)
                    begin
                        res.reply_byte = (b & dqr_pkg::OPHI_MASK) | {4'h0, rcode_reg};
                    end
                    else if (pos_reg >= POS_CNT)
                    begin
                        res.reply_byte = 8'h00;
                    end
                    else
                    begin
                        res.reply_byte = b;
                    end
                    if (pos_reg >= POS_HDRL)
                    begin
                        phase_next = dqr_pkg::PH_LENGTH;
                    end
                end
                dqr_pkg::PH_LENGTH:
                begin
                    res.in_reply   = 1'b1;
                    res.reply_byte = b;
                    if (b == 8'h00)
                    begin
                        name_end_next = pos_reg;
                        after_next    = '0;
                        phase_next    = dqr_pkg::PH_AFTER;
                    end
                    else
                    begin
                        if (!first_reg)
                        begin
                            res.name_char       = dqr_pkg::DOT_CHAR;
                            res.name_char_valid = 1'b1;
                        end
                        first_next      = 1'b0;
                        label_left_next = b;
                        phase_next      = dqr_pkg::PH_LABEL;
                    end
                end
                dqr_pkg::PH_LABEL:
                begin
                    res.in_reply        = 1'b1;
                    res.reply_byte      = b;
                    res.name_char       = b;
                    res.name_char_valid = 1'b1;
                    label_left_next     = label_dec;
                    if (label_dec == 8'd0)
                    begin
                        phase_next = dqr_pkg::PH_LENGTH;
                    end
                end
                default:
                begin
                    if (after_reg < dqr_pkg::TAIL_BYTES)
                    begin
                        res.in_reply   = 1'b1;
                        res.reply_byte = b;
                        if (after_reg == 3'd0)
                        begin
                            type_hi_next = b;
                        end
                        else if (after_reg == 3'd1)
                        begin
                            type_next = {type_hi_reg, b};
                        end
                        after_next = after_reg + 3'd1;
                    end
                end
            endcase
        end

        // Final-byte summary from the updated state
        if (word.last_byte)
        begin
            if (pos_next < POS_HDR)
            begin
                sum_len = '0;
            end
            else if (phase_next == dqr_pkg::PH_AFTER)
            begin
                sum_len = (after_next >= dqr_pkg::TAIL_BYTES) ?
                          SUM_W'(name_end_next) + SUM_W'(5) :
                          SUM_W'(name_end_next) + SUM_W'(1);
                if (after_next >= dqr_pkg::QTYPE_BYTES)
                begin
                    res.query_type = type_next;
                end
            end
            else
            begin
                sum_len = SUM_W'(pos_next);
            end
            res.reply_length = sum_len[dqr_pkg::REPLY_LEN_W-1:0];
        end
    end

    // Parse state; the last byte returns it to the idle values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= dqr_pkg::PH_HEADER;
            label_left_reg <= '0;
            first_reg      <= 1'b1;
            after_reg      <= '0;
            type_hi_reg    <= '0;
            type_reg       <= '0;
            name_end_reg   <= '0;
        end
        else if (take)
        begin
            if (word.last_byte)
            begin
                pos_reg        <= '0;
                phase_reg      <= dqr_pkg::PH_HEADER;
                label_left_reg <= '0;
                first_reg      <= 1'b1;
                after_reg      <= '0;
                type_hi_reg    <= '0;
                type_reg       <= '0;
                name_end_reg   <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                phase_reg      <= phase_next;
                label_left_reg <= label_left_next;
                first_reg      <= first_next;
                after_reg      <= after_next;
                type_hi_reg    <= type_hi_next;
                type_reg       <= type_next;
                name_end_reg   <= name_end_next;
            end
        end
    end

endmodule

[rtl/dqr_out_stage.sv]
// Result register driving the master-side stream.
// Depends on dqr_pkg for result_t and the output packing widths.
module dqr_out_stage
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  dqr_pkg::result_t                     res,
    output logic                                 ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dqr_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [dqr_pkg::OUT_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tlast
);

    logic             valid_reg;
    dqr_pkg::result_t res_reg;

    // Free when empty or the current word leaves this cycle
    assign ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            res_reg <= res;
        end
    end

    // Word packing
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'h00, res_reg.reply_length, res_reg.query_type,
                       res_reg.name_char, res_reg.reply_byte};
    assign m_tuser  = {res_reg.name_char_valid, res_reg.in_reply};
    assign m_tlast  = res_reg.end_of_message;

endmodule

[rtl/dns_query_reply_stream_unit.sv]
// Top level of the DNS query/reply byte stream unit.
// Instantiates dqr_in_stage, dqr_parse and dqr_out_stage; uses dqr_pkg.
//
//  Channel  | Dir | Word contents (low bit up)
//  ---------+-----+--------------------------------------------------------
//  s_*      | in  | tdata: request_byte[7:0]; tlast: last_byte
//  m_*      | out | tdata: reply_byte, name_char, query_type, reply_length;
//           |     | tuser: in_reply, name_char_valid; tlast: end_of_message
//  rcode_*  | in  | wr_en, wr_data[3:0]: response code
//
// One word per cycle sustained while m_tready stays high. A request byte is
// held in the input register, passes the combinational parse logic and is
// registered again in the result register, which drives m_tvalid.
// Reset clears the parse state, rcode and both valid flags.
// A stall on m_tready holds the result word and, once the input register
// is also full, drops s_tready.
module dns_query_reply_stream_unit
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rcode_wr_en,
    input  logic [3:0]  rcode_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] request_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] reply_byte, [15:8] name_char,
                                   // [31:16] query_type, [41:32] reply_length
    output logic [1:0]  m_tuser,   // [0] in_reply, [1] name_char_valid
    output logic        m_tlast    // end_of_message
);

    logic              word_valid;
    dqr_pkg::in_word_t word;
    logic              take;
    logic              res_ready;
    dqr_pkg::result_t  res;

    dqr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    dqr_parse
    #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    )
    u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rcode_wr_en   (rcode_wr_en),
        .rcode_wr_data (rcode_wr_data),
        .word_valid    (word_valid),
        .word          (word),
        .res_ready     (res_ready),
        .take          (take),
        .res           (res)
    );

    dqr_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .res      (res),
        .ready    (res_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
